[hdl/hrlp_pkg.sv]
package hrlp_pkg;

  // Version counters saturate at 2^VERSION_WIDTH - 1
  localparam int VERSION_WIDTH = 8;
  localparam int VER_CALC_W    = VERSION_WIDTH + 5;
  localparam logic [VERSION_WIDTH-1:0] VER_MAX = '1;

  typedef logic [VERSION_WIDTH-1:0] ver_t;

  // Depth of the queue between the classifier and the parser
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Method words, first letter in the lowest byte
  localparam logic [3:0][7:0] WORD_GET  = {8'h00, 8'h54, 8'h45, 8'h47};
  localparam logic [3:0][7:0] WORD_POST = {8'h54, 8'h53, 8'h4F, 8'h50};
  localparam logic [3:0][7:0] WORD_HEAD = {8'h44, 8'h41, 8'h45, 8'h48};

  localparam logic [1:0] METH_GET     = 2'd0;
  localparam logic [1:0] METH_POST    = 2'd1;
  localparam logic [1:0] METH_HEAD    = 2'd2;
  localparam logic [1:0] METH_UNKNOWN = 2'd3;

  localparam logic [2:0] LEN_MAX = 3'd5;

  typedef enum logic [2:0] {
    ST_MORE      = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_METHOD = 3'd2,
    ST_BAD_URI   = 3'd3,
    ST_BAD_PROTO = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_START, PH_METHOD, PH_SP_URI, PH_URI, PH_SP_PROTO,
    PH_H, PH_HT, PH_HTT, PH_HTTP, PH_MAJ_FIRST, PH_MAJ,
    PH_MIN_FIRST, PH_MIN, PH_SP_TAIL, PH_ALMOST
  } phase_e;

  // Classified byte handed from the front end to the parser
  typedef struct packed {
    logic [7:0] data;
    logic       upper;
    logic       digit;
    logic       sp;
    logic       cr;
    logic       lf;
    logic       slash;
    logic       dot;
    logic       h;
    logic       t;
    logic       p;
  } item_t;

  // Result beat, status in the lowest bits
  typedef struct packed {
    logic       uri_start;
    logic       uri_byte;
    logic [7:0] version_minor;
    logic [7:0] version_major;
    logic [1:0] method_code;
    logic [2:0] status;
  } res_t;

  localparam int RES_W   = $bits(res_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

  // v * 10 + d, saturating
  function automatic ver_t ver_push(ver_t v, logic [3:0] d);
    logic [VER_CALC_W-1:0] n;
    n = (VER_CALC_W'(v) << 3) + (VER_CALC_W'(v) << 1) + VER_CALC_W'(d);
    if (n > VER_CALC_W'(VER_MAX)) begin
      return VER_MAX;
    end
    return n[VERSION_WIDTH-1:0];
  endfunction

endpackage

[hdl/hrlp_front.sv]
module hrlp_front
  import hrlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output item_t      out_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    item_d.data  = in_data_i;
    item_d.upper = (in_data_i >= CH_A) && (in_data_i <= CH_Z);
    item_d.digit = (in_data_i >= CH_0) && (in_data_i <= CH_9);
    item_d.sp    = (in_data_i == CH_SP);
    item_d.cr    = (in_data_i == CH_CR);
    item_d.lf    = (in_data_i == CH_LF);
    item_d.slash = (in_data_i == CH_SLASH);
    item_d.dot   = (in_data_i == CH_DOT);
    item_d.h     = (in_data_i == CH_H);
    item_d.t     = (in_data_i == CH_T);
    item_d.p     = (in_data_i == CH_P);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[hdl/hrlp_fifo.sv]
module hrlp_fifo
  import hrlp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  item_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != FIFO_CW'(FIFO_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

[hdl/hrlp_back.sv]
module hrlp_back
  import hrlp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  phase_e phase_q, phase_d;
  logic [3:0][7:0] letters_q, letters_d;
  logic [2:0] len_q, len_d;
  logic [1:0] meth_q, meth_d;
  ver_t maj_q, maj_d;
  ver_t min_q, min_d;
  logic ovalid_q, ovalid_d;
  res_t res_q, res_d;

  status_e status_s;
  logic    ub_s, us_s;
  logic    take;
  item_t   c;

  assign c          = in_item_i;
  assign in_ready_o = !ovalid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Per-phase status, URI marks and updates of the method and version state
  always_comb begin
    status_s  = ST_MORE;
    ub_s      = 1'b0;
    us_s      = 1'b0;
    letters_d = letters_q;
    len_d     = len_q;
    meth_d    = meth_q;
    maj_d     = maj_q;
    min_d     = min_q;
    unique case (phase_q)
      PH_START: begin
        if (c.upper) begin
          letters_d = {8'h00, 8'h00, 8'h00, c.data};
          len_d     = 3'd1;
        end else if (!c.cr && !c.lf) begin
          status_s = ST_BAD_METHOD;
        end
      end
      PH_METHOD: begin
        if (c.sp) begin
          priority if (len_q == 3'd3 && letters_q == WORD_GET) begin
            meth_d = METH_GET;
          end else if (len_q >= 3'd4 && letters_q == WORD_POST) begin
            meth_d = METH_POST;
          end else if (len_q >= 3'd4 && letters_q == WORD_HEAD) begin
            meth_d = METH_HEAD;
          end else begin
            meth_d = METH_UNKNOWN;
          end
        end else if (c.upper) begin
          if (len_q < 3'd4) begin
            letters_d[len_q[1:0]] = c.data;
          end
          if (len_q < LEN_MAX) begin
            len_d = len_q + 3'd1;
          end
        end else begin
          status_s = ST_BAD_METHOD;
        end
      end
      PH_SP_URI: begin
        if (c.slash) begin
          ub_s = 1'b1;
          us_s = 1'b1;
        end else if (!c.sp) begin
          status_s = ST_BAD_URI;
        end
      end
      PH_URI: begin
        ub_s = !c.sp;
      end
      PH_SP_PROTO: begin
        if (!c.h && !c.sp) begin
          status_s = ST_BAD_URI;
        end
      end
      PH_H, PH_HT: begin
        if (!c.t) begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_HTT: begin
        if (!c.p) begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_HTTP: begin
        if (!c.slash) begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_MAJ_FIRST: begin
        if (c.digit) begin
          maj_d = ver_push('0, c.data[3:0]);
        end else begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_MAJ: begin
        if (c.digit) begin
          maj_d = ver_push(maj_q, c.data[3:0]);
        end else if (!c.dot) begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_MIN_FIRST: begin
        if (c.digit) begin
          min_d = ver_push('0, c.data[3:0]);
        end else begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_MIN: begin
        if (c.digit) begin
          min_d = ver_push(min_q, c.data[3:0]);
        end else if (c.lf) begin
          status_s = ST_DONE;
        end else if (!c.dot && !c.cr) begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_SP_TAIL: begin
        if (c.lf) begin
          status_s = ST_DONE;
        end else if (!c.cr && !c.sp) begin
          status_s = ST_BAD_PROTO;
        end
      end
      PH_ALMOST: begin
        status_s = c.lf ? ST_DONE : ST_BAD_PROTO;
      end
      default: begin
        status_s = ST_MORE;
      end
    endcase
  end

  // Next phase; any final status sends the parser back to start
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_START:     if (c.upper) phase_d = PH_METHOD;
      PH_METHOD:    if (c.sp) phase_d = PH_SP_URI;
      PH_SP_URI:    if (c.slash) phase_d = PH_URI;
      PH_URI:       if (c.sp) phase_d = PH_SP_PROTO;
      PH_SP_PROTO:  if (c.h) phase_d = PH_H;
      PH_H:         phase_d = PH_HT;
      PH_HT:        phase_d = PH_HTT;
      PH_HTT:       phase_d = PH_HTTP;
      PH_HTTP:      phase_d = PH_MAJ_FIRST;
      PH_MAJ_FIRST: phase_d = PH_MAJ;
      PH_MAJ:       if (c.dot) phase_d = PH_MIN_FIRST;
      PH_MIN_FIRST: phase_d = PH_MIN;
      PH_MIN: begin
        if (c.dot) begin
          phase_d = PH_SP_TAIL;
        end else if (c.cr) begin
          phase_d = PH_ALMOST;
        end
      end
      PH_SP_TAIL:   if (c.cr) phase_d = PH_ALMOST;
      PH_ALMOST:    phase_d = PH_START;
      default:      phase_d = PH_START;
    endcase
    if (status_s != ST_MORE) begin
      phase_d = PH_START;
    end
  end

  always_comb begin
    res_d.status        = status_s;
    res_d.method_code   = meth_d;
    res_d.version_major = 8'(maj_d);
    res_d.version_minor = 8'(min_d);
    res_d.uri_byte      = ub_s;
    res_d.uri_start     = us_s;
    ovalid_d = ovalid_q;
    if (take) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      letters_q <= '0;
      len_q     <= '0;
      meth_q    <= METH_UNKNOWN;
      maj_q     <= '0;
      min_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (take) begin
        phase_q   <= phase_d;
        letters_q <= letters_d;
        len_q     <= len_d;
        meth_q    <= meth_d;
        maj_q     <= maj_d;
        min_q     <= min_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_res_o   = res_q;

endmodule

[hdl/http_request_line_parser_unit.sv]
// Path: a byte accepted on s_axis passes the classifier register, the queue and
//   the result register before its result beat shows on m_axis.
// Throughput: one byte per clock while m_axis_tready does not stall the result register.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and
//   queue, returns the parser to its start phase with method unknown and
//   both version counts at zero.
module http_request_line_parser_unit
  import hrlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte stream in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  // Result stream out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [2:0] status, [4:3] method_code, [12:5] version_major,
  // [20:13] version_minor, [21] uri_byte, [22] uri_start, [23] zero
  output logic [TDATA_W-1:0] m_axis_tdata
);

  // Front end to queue
  logic  fr_valid, fr_ready;
  item_t fr_item;
  // Queue to parser
  logic  q_valid, q_ready;
  item_t q_item;
  res_t  res;

  // Classify each byte into the flags the parser needs and register them
  hrlp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  // Decouple the two halves so a stalled sink does not stall the classifier at once
  hrlp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  // Advance the request-line state machine one byte per beat and hold the result
  hrlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pad the result up to whole bytes
  assign m_axis_tdata = TDATA_W'(res);

endmodule

[hdl/hrlp_checker.sv]
module hrlp_checker
  import hrlp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [7:0]         s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_BAD_PROTO)
    else $error("status code out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21] && m_axis_tdata[2:0] == ST_MORE)
    else $error("uri start without uri byte or with final status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_MORE |-> !m_axis_tdata[21])
    else $error("uri byte flagged on a final status");

  // Hold a stalled input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input beat dropped or changed while stalled");

endmodule

bind http_request_line_parser_unit hrlp_checker u_hrlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import hrlp_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int STREAM_BYTES = 2000;
  localparam int DRAIN_CYCLES = 16;

  // Golden request-line walker plus the queue of result beats still owed by the block
  class request_line_scoreboard;
    phase_e          phase;
    logic [3:0][7:0] letters;
    int unsigned     word_len;
    logic [1:0]      meth;
    ver_t            major_v;
    ver_t            minor_v;
    res_t            owed_q[$];
    int unsigned     fail_count;
    int unsigned     status_seen[5];

    function new();
      phase      = PH_START;
      letters    = '0;
      word_len   = 0;
      meth       = METH_UNKNOWN;
      major_v    = '0;
      minor_v    = '0;
      fail_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit letters_match(logic [3:0][7:0] w);
      for (int i = 0; i < 4; i++) begin
        if (letters[i] != w[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // GET must be exactly three letters; POST and HEAD only look at the first four
    function logic [1:0] classify_word();
      if (word_len == 3 && letters_match(WORD_GET)) return METH_GET;
      if (word_len >= 4 && letters_match(WORD_POST)) return METH_POST;
      if (word_len >= 4 && letters_match(WORD_HEAD)) return METH_HEAD;
      return METH_UNKNOWN;
    endfunction

    function ver_t push_digit(ver_t v, logic [7:0] c);
      int unsigned n;
      n = v * 10 + (c - CH_0);
      return (n > VER_MAX) ? VER_MAX : ver_t'(n);
    endfunction

    // Advance the walker by one accepted byte and queue the beat it owes
    function void note_byte(logic [7:0] c);
      status_e st;
      phase_e  nxt;
      res_t    r;
      logic    ub;
      logic    us;
      logic    upper;
      logic    digit;
      st    = ST_MORE;
      nxt   = phase;
      ub    = 1'b0;
      us    = 1'b0;
      upper = (c >= CH_A) && (c <= CH_Z);
      digit = (c >= CH_0) && (c <= CH_9);
      case (phase)
        PH_START: begin
          if (upper) begin
            letters    = '0;
            letters[0] = c;
            word_len   = 1;
            nxt        = PH_METHOD;
          end else if (c != CH_CR && c != CH_LF) begin
            st = ST_BAD_METHOD;
          end
        end
        PH_METHOD: begin
          if (c == CH_SP) begin
            meth = classify_word();
            nxt  = PH_SP_URI;
          end else if (upper) begin
            if (word_len < 4) letters[word_len] = c;
            if (word_len < LEN_MAX) word_len++;
          end else begin
            st = ST_BAD_METHOD;
          end
        end
        PH_SP_URI: begin
          if (c == CH_SLASH) begin
            ub  = 1'b1;
            us  = 1'b1;
            nxt = PH_URI;
          end else if (c != CH_SP) begin
            st = ST_BAD_URI;
          end
        end
        PH_URI: begin
          if (c == CH_SP) nxt = PH_SP_PROTO;
          else ub = 1'b1;
        end
        PH_SP_PROTO: begin
          if (c == CH_H) nxt = PH_H;
          else if (c != CH_SP) st = ST_BAD_URI;
        end
        PH_H: begin
          if (c == CH_T) nxt = PH_HT;
          else st = ST_BAD_PROTO;
        end
        PH_HT: begin
          if (c == CH_T) nxt = PH_HTT;
          else st = ST_BAD_PROTO;
        end
        PH_HTT: begin
          if (c == CH_P) nxt = PH_HTTP;
          else st = ST_BAD_PROTO;
        end
        PH_HTTP: begin
          if (c == CH_SLASH) nxt = PH_MAJ_FIRST;
          else st = ST_BAD_PROTO;
        end
        PH_MAJ_FIRST: begin
          if (digit) begin
            major_v = push_digit('0, c);
            nxt     = PH_MAJ;
          end else begin
            st = ST_BAD_PROTO;
          end
        end
        PH_MAJ: begin
          if (digit) major_v = push_digit(major_v, c);
          else if (c == CH_DOT) nxt = PH_MIN_FIRST;
          else st = ST_BAD_PROTO;
        end
        PH_MIN_FIRST: begin
          if (digit) begin
            minor_v = push_digit('0, c);
            nxt     = PH_MIN;
          end else begin
            st = ST_BAD_PROTO;
          end
        end
        PH_MIN: begin
          if (digit) minor_v = push_digit(minor_v, c);
          else if (c == CH_DOT) nxt = PH_SP_TAIL;
          else if (c == CH_CR) nxt = PH_ALMOST;
          else if (c == CH_LF) st = ST_DONE;
          else st = ST_BAD_PROTO;
        end
        PH_SP_TAIL: begin
          if (c == CH_CR) nxt = PH_ALMOST;
          else if (c == CH_LF) st = ST_DONE;
          else if (c != CH_SP) st = ST_BAD_PROTO;
        end
        PH_ALMOST: begin
          if (c == CH_LF) st = ST_DONE;
          else st = ST_BAD_PROTO;
        end
        default: nxt = PH_START;
      endcase
      if (st != ST_MORE) nxt = PH_START;
      phase = nxt;

      r               = '0;
      r.status        = st;
      r.method_code   = meth;
      r.version_major = major_v;
      r.version_minor = minor_v;
      r.uri_byte      = ub;
      r.uri_start     = us;
      owed_q.insert(owed_q.size(), r);
      status_seen[st]++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    // Match one result beat against the oldest owed beat
    function void check_beat(logic [TDATA_W-1:0] tdata);
      res_t got;
      res_t want;
      got = tdata[RES_W-1:0];
      if (owed_q.size() == 0) begin
        $error("result beat %h arrived with nothing outstanding", tdata);
        fail_count++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("method_code", want.method_code, got.method_code);
      compare_field("version_major", want.version_major, got.version_major);
      compare_field("version_minor", want.version_minor, got.version_minor);
      compare_field("uri_byte", want.uri_byte, got.uri_byte);
      compare_field("uri_start", want.uri_start, got.uri_start);
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;

  logic [15:0]        stall_cycle   = '0;
  int unsigned        idle_cycles   = 0;
  logic [7:0]         stim_q[$];

  request_line_scoreboard sb = new();

  http_request_line_parser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver back-pressure: rotate through free-running, random, periodic and light stalls
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 16'd1;
    case (stall_cycle[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 0);
      2'd2:    m_axis_tready <= (stall_cycle[2:0] < 3'd3);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Sample both handshakes on the edge; the watchdog trips when neither side moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_byte(logic [7:0] b);
    stim_q.insert(stim_q.size(), b);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void push_digits(int unsigned count);
    for (int i = 0; i < count; i++) add_byte(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  // One well-formed request line with random content, sometimes damaged or cut short
  function automatic void add_request_line();
    int unsigned start_at;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  b;
    start_at = stim_q.size();
    if ($urandom_range(0, 7) == 0) add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    case ($urandom_range(0, 9))
      0, 1:    push_text("GET");
      2, 3:    push_text("POST");
      4, 5:    push_text("HEAD");
      6:       push_text("POSTED");
      7: begin
        if ($urandom_range(0, 1)) push_text("HEADERS");
        else push_text("GETS");
      end
      8:       push_text("GE");
      default: begin
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) add_byte(8'(CH_A + $urandom_range(0, 25)));
      end
    endcase
    repeat ($urandom_range(1, 3)) add_byte(CH_SP);
    add_byte(CH_SLASH);
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      // Mostly printable path bytes; any byte but a space now and then, CR and LF included
      b = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h21, 8'h7E));
      if (b == CH_SP) b = CH_CR;
      add_byte(b);
    end
    repeat ($urandom_range(1, 3)) add_byte(CH_SP);
    push_text("HTTP/");
    push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1);
    add_byte(CH_DOT);
    push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1);
    // Trailing spaces are only legal after the optional dot
    if ($urandom_range(0, 2) == 0) begin
      add_byte(CH_DOT);
      repeat ($urandom_range(0, 2)) add_byte(CH_SP);
    end
    if ($urandom_range(0, 1)) add_byte(CH_CR);
    add_byte(CH_LF);

    len = stim_q.size() - start_at;
    if ($urandom_range(0, 4) == 0) begin
      stim_q[start_at + $urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    end else if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, len - 1);
      repeat (cut) void'(stim_q.pop_back());
    end
  endfunction

  // Stream the byte queue in bursts of random length, random gaps in between
  task automatic drive_bytes();
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (int n = 0; n < burst && idx < stim_q.size(); n++) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stim_q[idx];
        do @(posedge clk_i); while (!s_axis_tready);
        idx++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 5) == 0) ? 12 : 3);
      if (gap > 0 || idx >= stim_q.size()) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    // Directed opener: skipped line break, HEAD, URI holding CR and NUL, a major
    // version that saturates, optional dot with a trailing space, bare LF, then
    // the two extreme bytes rejected as a method
    add_byte(CH_LF);
    push_text("HEAD /");
    add_byte(CH_CR);
    add_byte(8'h00);
    push_text(" HTTP/300.9. ");
    add_byte(CH_LF);
    add_byte(8'hFF);
    add_byte(8'h00);

    while (stim_q.size() < STREAM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_request_line();
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    drive_bytes();
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Streamed %0d bytes: %0d lines completed, %0d bytes still waiting for more",
             stim_q.size(), sb.status_seen[ST_DONE], sb.status_seen[ST_MORE]);
    $display("Rejects seen: %0d method, %0d uri, %0d protocol",
             sb.status_seen[ST_BAD_METHOD], sb.status_seen[ST_BAD_URI],
             sb.status_seen[ST_BAD_PROTO]);
    if (sb.fail_count == 0 && sb.owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[http_request_line_parser_unit.f]
hdl/hrlp_pkg.sv
hdl/hrlp_front.sv
hdl/hrlp_fifo.sv
hdl/hrlp_back.sv
hdl/http_request_line_parser_unit.sv
hdl/hrlp_checker.sv
test/testbench.sv
